/* hw/rtl/tprm_pkg.sv */
// Shared types and constants of the threshold pulse rate meter.
package tprm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int TICK_W    = 10;
    localparam int TIMEOUT_W = 16;
    localparam int ELAPSED_W = 17;
    localparam int RATE_W    = 16;
    localparam int DIGIT_W   = 4;
    localparam int BCD_W     = 20;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [RATE_W-1:0] RATE_NUM = 16'd60000;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

    localparam logic [SAMPLE_W-1:0]  THRESHOLD_RST = 12'd190;
    localparam logic [TICK_W-1:0]    TICK_RST      = 10'd40;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_LOAD
    } tprm_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIV,
        PH_BCD
    } tprm_phase_t;

endpackage

/* hw/rtl/tprm_if.sv */
// Channel interfaces: sample input, result output and register write port.
interface tprm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [tprm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tprm_result_if;
    logic                          valid;
    logic                          ready;
    logic [tprm_pkg::SAMPLE_W-1:0] sample_echo;
    logic                          beat;
    logic [tprm_pkg::RATE_W-1:0]   rate_bpm;
    logic [tprm_pkg::DIGIT_W-1:0]  ones_digit;
    logic [tprm_pkg::DIGIT_W-1:0]  tens_digit;
    logic [tprm_pkg::DIGIT_W-1:0]  hundreds_digit;
    logic                          zero_interval;
    logic                          display_clear;

    modport source (output valid, output sample_echo, output beat, output rate_bpm,
                    output ones_digit, output tens_digit, output hundreds_digit,
                    output zero_interval, output display_clear, input ready);
    modport sink   (input valid, input sample_echo, input beat, input rate_bpm,
                    input ones_digit, input tens_digit, input hundreds_digit,
                    input zero_interval, input display_clear, output ready);
endinterface

interface tprm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tprm_pkg::CFG_IDX_W-1:0] index;
    logic [tprm_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/tprm_rate_unit.sv */
// Bit-serial 60000/elapsed divider followed by a bit-serial BCD split.
module tprm_rate_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [tprm_pkg::ELAPSED_W-1:0]        divisor,
    output logic                                  done,
    output logic [tprm_pkg::RATE_W-1:0]           rate,
    output logic [tprm_pkg::DIGIT_W-1:0]          ones,
    output logic [tprm_pkg::DIGIT_W-1:0]          tens,
    output logic [tprm_pkg::DIGIT_W-1:0]          hundreds
);

    localparam int NDIG = tprm_pkg::BCD_W / tprm_pkg::DIGIT_W;

    tprm_pkg::tprm_phase_t phase_reg, phase_next;
    logic [tprm_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [tprm_pkg::ELAPSED_W-1:0] rem_reg, rem_next;
    logic [tprm_pkg::ELAPSED_W-1:0] div_reg, div_next;
    logic [tprm_pkg::RATE_W-1:0]    num_reg, num_next;
    logic [tprm_pkg::RATE_W-1:0]    rate_reg, rate_next;
    logic [tprm_pkg::BCD_W-1:0]     bcd_reg, bcd_next;

    logic [tprm_pkg::ELAPSED_W:0]   rem_sh;
    logic [tprm_pkg::ELAPSED_W:0]   div_ext;
    logic                           q_bit;
    logic [tprm_pkg::BCD_W-1:0]     bcd_adj;
    logic                           last;

    assign last    = (step_reg == tprm_pkg::LAST_STEP);
    assign rem_sh  = {rem_reg, num_reg[tprm_pkg::RATE_W-1]};
    assign div_ext = {1'b0, div_reg};
    assign q_bit   = (rem_sh >= div_ext);

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*tprm_pkg::DIGIT_W +: tprm_pkg::DIGIT_W] >= 4'd5)
                bcd_adj[i*tprm_pkg::DIGIT_W +: tprm_pkg::DIGIT_W] =
                    bcd_reg[i*tprm_pkg::DIGIT_W +: tprm_pkg::DIGIT_W] + 4'd3;
            else
                bcd_adj[i*tprm_pkg::DIGIT_W +: tprm_pkg::DIGIT_W] =
                    bcd_reg[i*tprm_pkg::DIGIT_W +: tprm_pkg::DIGIT_W];
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            tprm_pkg::PH_IDLE: if (start) phase_next = tprm_pkg::PH_DIV;
            tprm_pkg::PH_DIV:  if (last)  phase_next = tprm_pkg::PH_BCD;
            tprm_pkg::PH_BCD:  if (last)  phase_next = tprm_pkg::PH_IDLE;
            default:           phase_next = tprm_pkg::PH_IDLE;
        endcase
    end

    // datapath and status
    always_comb
    begin
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        num_next  = num_reg;
        rate_next = rate_reg;
        bcd_next  = bcd_reg;
        done      = 1'b0;
        unique case (phase_reg)
            tprm_pkg::PH_IDLE:
            begin
                if (start)
                begin
                    step_next = '0;
                    rem_next  = '0;
                    div_next  = divisor;
                    num_next  = tprm_pkg::RATE_NUM;
                end
            end
            tprm_pkg::PH_DIV:
            begin
                step_next = step_reg + 1'b1;
                rem_next  = q_bit ? tprm_pkg::ELAPSED_W'(rem_sh - div_ext)
                                  : rem_sh[tprm_pkg::ELAPSED_W-1:0];
                num_next  = {num_reg[tprm_pkg::RATE_W-2:0], q_bit};
                if (last)
                begin
                    rate_next = num_next;
                    bcd_next  = '0;
                end
            end
            tprm_pkg::PH_BCD:
            begin
                step_next = step_reg + 1'b1;
                bcd_next  = {bcd_adj[tprm_pkg::BCD_W-2:0], num_reg[tprm_pkg::RATE_W-1]};
                num_next  = {num_reg[tprm_pkg::RATE_W-2:0], 1'b0};
                done      = last;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tprm_pkg::PH_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        num_reg  <= num_next;
        rate_reg <= rate_next;
        bcd_reg  <= bcd_next;
    end

    assign rate     = rate_reg;
    assign ones     = bcd_reg[0 +: tprm_pkg::DIGIT_W];
    assign tens     = bcd_reg[tprm_pkg::DIGIT_W +: tprm_pkg::DIGIT_W];
    assign hundreds = bcd_reg[2*tprm_pkg::DIGIT_W +: tprm_pkg::DIGIT_W];

endmodule

/* hw/rtl/threshold_pulse_rate_meter.sv */
// Top level of the threshold pulse rate meter.
//
// samples: one 12-bit sensor reading per transfer. results: one item per
// processed sample with echo, beat flag, rate in bpm, its low three decimal
// digits, zero-interval and display-clear flags. cfg: register writes
// (0 threshold, 1 tick_ms, 2 timeout_ms, 3 run_enable), always ready. They must
// be issued only while the block is idle; the block itself does not enforce it.
// A sample that is not a beat, or a beat with zero elapsed time, goes from the
// pending registers into the result register in the load state. A beat with
// nonzero elapsed time first runs the rate unit: bit-serial division, then
// bit-serial BCD conversion. A new sample is taken once the previous one has
// moved into the result register. A stalled receiver holds one finished
// result while the next sample is computed. With run_enable 0 samples are
// taken and dropped without a result. Reset restores register defaults,
// clears the above-threshold flag and elapsed time, and empties the result
// register.
module threshold_pulse_rate_meter (
    input  logic          clk,
    input  logic          rst_n,
    tprm_sample_if.sink   samples,
    tprm_result_if.source results,
    tprm_cfg_if.sink      cfg
);

    tprm_pkg::tprm_state_t state_reg, state_next;

    logic [tprm_pkg::SAMPLE_W-1:0]  threshold_reg;
    logic [tprm_pkg::TICK_W-1:0]    tick_reg;
    logic [tprm_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                           run_reg;

    logic                           above_reg;
    logic [tprm_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    logic [tprm_pkg::SAMPLE_W-1:0]  pend_sample_reg;
    logic                           pend_beat_reg;
    logic                           pend_zero_reg;
    logic                           pend_clr_reg;
    logic                           pend_div_reg;

    logic                           out_valid_reg;
    logic [tprm_pkg::SAMPLE_W-1:0]  out_sample_reg;
    logic                           out_beat_reg;
    logic [tprm_pkg::RATE_W-1:0]    out_rate_reg;
    logic [tprm_pkg::DIGIT_W-1:0]   out_ones_reg;
    logic [tprm_pkg::DIGIT_W-1:0]   out_tens_reg;
    logic [tprm_pkg::DIGIT_W-1:0]   out_hund_reg;
    logic                           out_zero_reg;
    logic                           out_clr_reg;

    logic                           in_fire;
    logic                           take;
    logic                           above_now;
    logic                           beat_now;
    logic                           elapsed_zero;
    logic                           div_now;
    logic [tprm_pkg::ELAPSED_W-1:0] base_ms;
    logic [tprm_pkg::ELAPSED_W-1:0] sum_ms;
    logic                           clr_now;

    logic                           unit_start;
    logic                           unit_done;
    logic                           out_load;
    logic [tprm_pkg::RATE_W-1:0]    unit_rate;
    logic [tprm_pkg::DIGIT_W-1:0]   unit_ones;
    logic [tprm_pkg::DIGIT_W-1:0]   unit_tens;
    logic [tprm_pkg::DIGIT_W-1:0]   unit_hund;

    assign cfg.ready = 1'b1;
    assign in_fire   = samples.valid && samples.ready;
    assign take      = in_fire && run_reg;

    assign above_now    = (samples.sample >= threshold_reg);
    assign beat_now     = above_now && !above_reg;
    assign elapsed_zero = (elapsed_reg == '0);
    assign div_now      = beat_now && !elapsed_zero;
    assign base_ms      = beat_now ? '0 : elapsed_reg;
    assign sum_ms       = base_ms + tprm_pkg::ELAPSED_W'(tick_reg);
    assign clr_now      = (sum_ms > tprm_pkg::ELAPSED_W'(timeout_reg));
    assign elapsed_next = clr_now ? '0 : sum_ms;

    tprm_rate_unit u_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .divisor  (elapsed_reg),
        .done     (unit_done),
        .rate     (unit_rate),
        .ones     (unit_ones),
        .tens     (unit_tens),
        .hundreds (unit_hund)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tprm_pkg::ST_IDLE:
            begin
                if (take)
                    state_next = div_now ? tprm_pkg::ST_CALC : tprm_pkg::ST_LOAD;
            end
            tprm_pkg::ST_CALC:
            begin
                if (unit_done)
                    state_next = tprm_pkg::ST_LOAD;
            end
            tprm_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || results.ready)
                    state_next = tprm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tprm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        samples.ready = 1'b0;
        unit_start    = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            tprm_pkg::ST_IDLE:
            begin
                samples.ready = 1'b1;
                unit_start    = take && div_now;
            end
            tprm_pkg::ST_CALC:
            begin
                samples.ready = 1'b0;
            end
            tprm_pkg::ST_LOAD:
            begin
                out_load = !out_valid_reg || results.ready;
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tprm_pkg::ST_IDLE;
            threshold_reg <= tprm_pkg::THRESHOLD_RST;
            tick_reg      <= tprm_pkg::TICK_RST;
            timeout_reg   <= tprm_pkg::TIMEOUT_RST;
            run_reg       <= 1'b1;
            above_reg     <= 1'b0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    tprm_pkg::REG_THRESHOLD:
                        threshold_reg <= cfg.data[tprm_pkg::SAMPLE_W-1:0];
                    tprm_pkg::REG_TICK_MS:
                        tick_reg <= cfg.data[tprm_pkg::TICK_W-1:0];
                    tprm_pkg::REG_TIMEOUT_MS:
                        timeout_reg <= cfg.data[tprm_pkg::TIMEOUT_W-1:0];
                    tprm_pkg::REG_RUN_ENABLE:
                        run_reg <= cfg.data[0];
                    default:
                        run_reg <= run_reg;
                endcase
            end
            if (take)
            begin
                above_reg   <= above_now;
                elapsed_reg <= elapsed_next;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_sample_reg <= samples.sample;
            pend_beat_reg   <= beat_now;
            pend_zero_reg   <= beat_now && elapsed_zero;
            pend_clr_reg    <= clr_now;
            pend_div_reg    <= div_now;
        end
        if (out_load)
        begin
            out_sample_reg <= pend_sample_reg;
            out_beat_reg   <= pend_beat_reg;
            out_zero_reg   <= pend_zero_reg;
            out_clr_reg    <= pend_clr_reg;
            out_rate_reg   <= pend_div_reg ? unit_rate : '0;
            out_ones_reg   <= pend_div_reg ? unit_ones : '0;
            out_tens_reg   <= pend_div_reg ? unit_tens : '0;
            out_hund_reg   <= pend_div_reg ? unit_hund : '0;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.sample_echo    = out_sample_reg;
    assign results.beat           = out_beat_reg;
    assign results.rate_bpm       = out_rate_reg;
    assign results.ones_digit     = out_ones_reg;
    assign results.tens_digit     = out_tens_reg;
    assign results.hundreds_digit = out_hund_reg;
    assign results.zero_interval  = out_zero_reg;
    assign results.display_clear  = out_clr_reg;

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> state_reg == tprm_pkg::ST_CALC)
        else $error("rate unit finished outside of a calculation");

    a_start_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        unit_start |=> state_reg == tprm_pkg::ST_CALC)
        else $error("rate unit started without entering calculation");

    a_no_beat_no_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.beat) |->
            (results.rate_bpm == '0 && !results.zero_interval))
        else $error("rate or zero interval reported without a beat");

    a_zero_no_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.zero_interval) |-> results.rate_bpm == '0)
        else $error("nonzero rate on a zero interval");

endmodule
